@@ design/vtm_pkg.sv @@
package vtm_pkg;

  localparam int unsigned NUM_SLOTS   = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IDX_W       = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned ID_W        = 4;
  localparam int unsigned TIME_W      = 32;

  typedef enum logic [1:0] {
    F_TICK   = 2'd0,
    F_START  = 2'd1,
    F_CANCEL = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    K_FIRE   = 2'd0,
    K_START  = 2'd1,
    K_CANCEL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SLOT    = 2'd1,
    ST_ZERO_DELAY = 2'd2,
    ST_NOT_ACTIVE = 2'd3
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [TIME_W-1:0]  delay;
    logic               repeat_req;
    logic [ID_W-1:0]    slot;
  } req_t;

  typedef struct packed {
    kind_e              kind;
    logic [ID_W-1:0]    slot_id;
    status_e            status;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               repeating;
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  expiry;
  } slot_entry_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    slot_entry_t        data;
  } mem_wr_t;

endpackage

@@ design/vtm_slot_mem.sv @@
module vtm_slot_mem
  import vtm_pkg::*;
(
  input  logic             clk_i,
  input  mem_wr_t          wr_i,
  input  logic [IDX_W-1:0] raddr_i,
  output slot_entry_t      rdata_o
);

  slot_entry_t mem_q [NUM_SLOTS];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/vtm_core.sv @@
module vtm_core
  import vtm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  req_t             req_i,
  output logic             busy,
  output logic             res_valid_o,
  output res_t             res_o,
  output mem_wr_t          mem_wr_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  input  slot_entry_t      mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_TICK,
    S_DRAIN,
    S_FLUSH
  } state_e;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_SLOTS - 1);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               ev_v_q, ev_v_d;
  logic [IDX_W-1:0]   ev_idx_q, ev_idx_d;
  logic               pend_v_q, pend_v_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic [TIME_W-1:0]  delay_q, delay_d;
  logic               rep_q, rep_d;
  logic               res_valid_q, res_valid_d;
  res_t               res_q, res_d;

  logic [TIME_W-1:0]  add_a, add_b, sum;
  logic               hit;
  mem_wr_t            mem_wr;

  // shared adder: counter step, start expiry, reload
  always_comb begin
    unique case (state_q)
      S_IDLE: begin
        add_a = now_q;
        add_b = TIME_W'(1);
      end
      S_START: begin
        add_a = now_q;
        add_b = delay_q;
      end
      default: begin
        add_a = mem_rdata_i.expiry;
        add_b = mem_rdata_i.period;
      end
    endcase
  end

  assign sum = add_a + add_b;
  assign hit = ev_v_q && active_q[ev_idx_q] && (mem_rdata_i.expiry == now_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ev_v_d      = ev_v_q;
    ev_idx_d    = ev_idx_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    n_d         = n_q;
    now_d       = now_q;
    active_d    = active_q;
    delay_d     = delay_q;
    rep_d       = rep_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_wr      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          delay_d = req_i.delay;
          rep_d   = req_i.repeat_req;
          unique case (req_i.func)
            F_TICK: begin
              now_d    = sum;
              idx_d    = '0;
              ev_v_d   = 1'b0;
              pend_v_d = 1'b0;
              n_d      = '0;
              state_d  = S_TICK;
            end
            F_START: begin
              if (req_i.delay == '0) begin
                res_valid_d = 1'b1;
                res_d       = '{kind: K_START, slot_id: '0, status: ST_ZERO_DELAY,
                                last: 1'b1};
              end else begin
                idx_d   = '0;
                state_d = S_START;
              end
            end
            F_CANCEL: begin
              res_valid_d = 1'b1;
              if ((32'(req_i.slot) < NUM_SLOTS) && active_q[IDX_W'(req_i.slot)]) begin
                active_d[IDX_W'(req_i.slot)] = 1'b0;
                res_d = '{kind: K_CANCEL, slot_id: req_i.slot, status: ST_OK, last: 1'b1};
              end else begin
                res_d = '{kind: K_CANCEL, slot_id: req_i.slot, status: ST_NOT_ACTIVE,
                          last: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        if (!active_q[idx_q]) begin
          mem_wr.we             = 1'b1;
          mem_wr.addr           = idx_q;
          mem_wr.data.repeating = rep_q;
          mem_wr.data.period    = delay_q;
          mem_wr.data.expiry    = sum;
          active_d[idx_q]       = 1'b1;
          res_valid_d           = 1'b1;
          res_d   = '{kind: K_START, slot_id: ID_W'(idx_q), status: ST_OK, last: 1'b1};
          state_d = S_IDLE;
        end else if (idx_q == LastIdx) begin
          res_valid_d = 1'b1;
          res_d   = '{kind: K_START, slot_id: '0, status: ST_NO_SLOT, last: 1'b1};
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_TICK, S_DRAIN: begin
        if (hit) begin
          if (mem_rdata_i.repeating) begin
            mem_wr.we          = 1'b1;
            mem_wr.addr        = ev_idx_q;
            mem_wr.data        = mem_rdata_i;
            mem_wr.data.expiry = sum;
          end else begin
            active_d[ev_idx_q] = 1'b0;
          end
          if (n_q < CNT_W'(MAX_RESULTS)) begin
            if (pend_v_q) begin
              res_valid_d = 1'b1;
              res_d = '{kind: K_FIRE, slot_id: ID_W'(pend_idx_q), status: ST_OK,
                        last: 1'b0};
            end
            pend_v_d   = 1'b1;
            pend_idx_d = ev_idx_q;
            n_d        = n_q + CNT_W'(1);
          end
        end
        if (state_q == S_TICK) begin
          ev_v_d   = 1'b1;
          ev_idx_d = idx_q;
          if (idx_q == LastIdx) begin
            state_d = S_DRAIN;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end else begin
          ev_v_d  = 1'b0;
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (pend_v_q) begin
          res_valid_d = 1'b1;
          res_d = '{kind: K_FIRE, slot_id: ID_W'(pend_idx_q), status: ST_OK, last: 1'b1};
        end
        pend_v_d = 1'b0;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      ev_v_q      <= 1'b0;
      ev_idx_q    <= '0;
      pend_v_q    <= 1'b0;
      pend_idx_q  <= '0;
      n_q         <= '0;
      now_q       <= '0;
      active_q    <= '0;
      delay_q     <= '0;
      rep_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      ev_v_q      <= ev_v_d;
      ev_idx_q    <= ev_idx_d;
      pend_v_q    <= pend_v_d;
      pend_idx_q  <= pend_idx_d;
      n_q         <= n_d;
      now_q       <= now_d;
      active_q    <= active_d;
      delay_q     <= delay_d;
      rep_q       <= rep_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign mem_wr_o    = mem_wr;
  assign mem_raddr_o = idx_q;

`ifndef NO_ASSERTIONS
  a_fire_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == K_FIRE) |-> res_o.status == ST_OK)
    else $error("fire result with bad status");

  a_flush_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH |=> state_q == S_IDLE)
    else $error("flush did not return to idle");

  a_eval_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_v_q |-> (state_q == S_TICK) || (state_q == S_DRAIN))
    else $error("slot evaluation outside scan");

  a_start_claims : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START) && !active_q[idx_q] |=>
      active_q[$past(idx_q)] && (state_q == S_IDLE))
    else $error("start did not claim free slot");
`endif

endmodule

@@ design/virtual_timer_multiplexer_top.sv @@
// virtual timer multiplexer: up to NUM_SLOTS virtual timers on one 32-bit counter
// request channel: a request is taken when start is high and busy is low;
//   req_i.func selects tick, start timer or cancel timer
// result channel: res_valid_o marks a result on res_o for exactly one cycle;
//   res_o.last flags the final result of a request; the receiver cannot stall
// cancel and a zero-delay start: busy stays low, the answer appears the next cycle
// start: lowest free slot is searched one slot per cycle; the answer appears
//   in the same cycle as busy falls
// tick: counter steps at acceptance, then the slot table is scanned one slot a
//   cycle through the shared adder and comparator; fire results emerge lowest
//   slot first during the scan, the final one in the same cycle as busy falls;
//   nothing expiring gives no result
// a func value of 3 is ignored
// reset clears the counter, all slot active bits and the sequencer; the slot
//   table itself holds no reset value and is only read for active slots
module virtual_timer_multiplexer_top
  import vtm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic res_valid_o,
  output res_t res_o
);

  mem_wr_t          mem_wr;
  logic [IDX_W-1:0] mem_raddr;
  slot_entry_t      mem_rdata;

  vtm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .mem_wr_o    (mem_wr),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  vtm_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
